FILE: design/mau_pkg.sv
// Shared types, codes and microcode store for the modular arithmetic unit.
package mau_pkg;

  // Default sizes and the modulus value after reset
  localparam int unsigned OPERAND_WIDTH_DEF  = 30;
  localparam int unsigned EXPONENT_WIDTH_DEF = 64;
  localparam logic [31:0] MODULUS_RESET      = 32'd1000000007;

  // Fixed field widths of an input beat
  localparam int unsigned OP_W        = 3;
  localparam int unsigned EXP_FIELD_W = 63;
  localparam int unsigned RAW_W       = 64;

  // Operation codes carried in the op field
  localparam logic [OP_W-1:0] OP_REDUCE = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB    = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL    = 3'd3;
  localparam logic [OP_W-1:0] OP_POW    = 3'd4;
  localparam logic [OP_W-1:0] OP_INV    = 3'd5;
  localparam logic [OP_W-1:0] OP_DIV    = 3'd6;

  // Register map (byte addresses)
  localparam int unsigned  PADDR_W  = 2;
  localparam logic [PADDR_W-1:0] REG_MODULUS = 2'd0;

  // Microprogram counter
  localparam int unsigned UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  // Datapath actions of one control word
  typedef enum logic [4:0] {
    U_NOP,
    U_LD_A,     // serial load: operand_a, addend one
    U_LD_B,     // serial load: operand_b, addend one
    U_LD_RAW,   // serial load: magnitude of raw_value, addend one
    U_LD_MUL,   // serial load: rb times ra
    U_LD_SQR,   // serial load: acc times acc
    U_LD_MULB,  // serial load: acc times base
    U_LD_DIV,   // serial load: acc times ra
    U_RUN,      // one shift-and-reduce step, held until the count runs out
    U_MV_RA,
    U_MV_RB,
    U_RAW_FIX,  // fold a negative raw value into 0..m-1
    U_ADD,
    U_SUB,
    U_POW_E,    // set up power with the exponent field
    U_INV_A,    // set up power of ra with m-2
    U_INV_B,    // set up power of rb with m-2
    U_E_NEXT,   // advance to the next exponent bit
    U_CLR
  } uop_e;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEXT,
    C_JMP,
    C_M_ZERO,
    C_M_LT2,
    C_RA_ZERO,
    C_RB_ZERO,
    C_EBIT_CLR,
    C_EMORE,
    C_NODIV,
    C_DISPATCH
  } cond_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } seq_state_e;

  typedef struct packed {
    uop_e  uop;
    cond_e cond;
    upc_t  target;
    logic  last;
  } ctl_t;

  // Program labels
  localparam upc_t L_PREP  = 5'd0;
  localparam upc_t L_RAW   = 5'd7;
  localparam upc_t L_ADD   = 5'd10;
  localparam upc_t L_SUB   = 5'd11;
  localparam upc_t L_MUL   = 5'd12;
  localparam upc_t L_POW   = 5'd14;
  localparam upc_t L_INV   = 5'd15;
  localparam upc_t L_DIV   = 5'd18;
  localparam upc_t L_LOOP  = 5'd21;
  localparam upc_t L_ENEXT = 5'd26;
  localparam upc_t L_DONE  = 5'd30;
  localparam upc_t L_ZERO  = 5'd31;

  function automatic ctl_t cw(uop_e u, cond_e c, upc_t t, logic l);
    return '{uop: u, cond: c, target: t, last: l};
  endfunction

  // Microcode store
  function automatic ctl_t ucode_rom(upc_t addr);
    ctl_t w;
    w = cw(U_CLR, C_NEXT, L_ZERO, 1'b1);
    unique case (addr)
      // a zero modulus gives zero; else reduce both operands, then branch on the operation
      5'd0:  w = cw(U_NOP,     C_M_ZERO,   L_ZERO,  1'b0);
      5'd1:  w = cw(U_LD_A,    C_NEXT,     L_PREP,  1'b0);
      5'd2:  w = cw(U_RUN,     C_NEXT,     L_PREP,  1'b0);
      5'd3:  w = cw(U_MV_RA,   C_NEXT,     L_PREP,  1'b0);
      5'd4:  w = cw(U_LD_B,    C_NEXT,     L_PREP,  1'b0);
      5'd5:  w = cw(U_RUN,     C_NEXT,     L_PREP,  1'b0);
      5'd6:  w = cw(U_MV_RB,   C_DISPATCH, L_PREP,  1'b0);
      // reduce raw value
      5'd7:  w = cw(U_LD_RAW,  C_NEXT,     L_PREP,  1'b0);
      5'd8:  w = cw(U_RUN,     C_NEXT,     L_PREP,  1'b0);
      5'd9:  w = cw(U_RAW_FIX, C_NEXT,     L_PREP,  1'b1);
      // add, subtract
      5'd10: w = cw(U_ADD,     C_NEXT,     L_PREP,  1'b1);
      5'd11: w = cw(U_SUB,     C_NEXT,     L_PREP,  1'b1);
      // multiply
      5'd12: w = cw(U_LD_MUL,  C_NEXT,     L_PREP,  1'b0);
      5'd13: w = cw(U_RUN,     C_NEXT,     L_PREP,  1'b1);
      // power
      5'd14: w = cw(U_POW_E,   C_JMP,      L_LOOP,  1'b0);
      // inverse
      5'd15: w = cw(U_NOP,     C_M_LT2,    L_ZERO,  1'b0);
      5'd16: w = cw(U_NOP,     C_RA_ZERO,  L_ZERO,  1'b0);
      5'd17: w = cw(U_INV_A,   C_JMP,      L_LOOP,  1'b0);
      // divide: invert b, then multiply by a after the loop
      5'd18: w = cw(U_NOP,     C_M_LT2,    L_ZERO,  1'b0);
      5'd19: w = cw(U_NOP,     C_RB_ZERO,  L_ZERO,  1'b0);
      5'd20: w = cw(U_INV_B,   C_NEXT,     L_PREP,  1'b0);
      // square and multiply, top exponent bit first
      5'd21: w = cw(U_LD_SQR,  C_NEXT,     L_PREP,  1'b0);
      5'd22: w = cw(U_RUN,     C_NEXT,     L_PREP,  1'b0);
      5'd23: w = cw(U_NOP,     C_EBIT_CLR, L_ENEXT, 1'b0);
      5'd24: w = cw(U_LD_MULB, C_NEXT,     L_PREP,  1'b0);
      5'd25: w = cw(U_RUN,     C_NEXT,     L_PREP,  1'b0);
      5'd26: w = cw(U_E_NEXT,  C_EMORE,    L_LOOP,  1'b0);
      5'd27: w = cw(U_NOP,     C_NODIV,    L_DONE,  1'b0);
      5'd28: w = cw(U_LD_DIV,  C_NEXT,     L_PREP,  1'b0);
      5'd29: w = cw(U_RUN,     C_NEXT,     L_PREP,  1'b1);
      5'd30: w = cw(U_NOP,     C_NEXT,     L_PREP,  1'b1);
      5'd31: w = cw(U_CLR,     C_NEXT,     L_PREP,  1'b1);
      default: w = cw(U_CLR,   C_NEXT,     L_ZERO,  1'b1);
    endcase
    return w;
  endfunction

  // Entry point of each operation after the operands are reduced
  function automatic upc_t dispatch(logic [OP_W-1:0] op);
    upc_t t;
    t = L_ZERO;
    unique case (op)
      OP_REDUCE: t = L_RAW;
      OP_ADD:    t = L_ADD;
      OP_SUB:    t = L_SUB;
      OP_MUL:    t = L_MUL;
      OP_POW:    t = L_POW;
      OP_INV:    t = L_INV;
      OP_DIV:    t = L_DIV;
      default:   t = L_ZERO;
    endcase
    return t;
  endfunction

endpackage

FILE: design/modular_arithmetic_unit.sv
// Modular arithmetic unit: microcoded sequencer over a bit-serial modular datapath.
// Each beat first reduces both operands (W = OPERAND_WIDTH, E = min(EXPONENT_WIDTH, 63)),
//   then runs add/sub, reduce of raw_value, mul, pow over E exponent bits, inverse as pow
//   with m-2 over W bits, or divide as b inverted times a; a zero modulus gives zero.
// Flow: one bit per cycle, new beats only when idle; an untaken result holds the last step.
// Reset: asynchronous, active low; the modulus returns to 1000000007, no result pending.
module modular_arithmetic_unit #(
  parameter int unsigned OPERAND_WIDTH  = mau_pkg::OPERAND_WIDTH_DEF,
  parameter int unsigned EXPONENT_WIDTH = mau_pkg::EXPONENT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mau_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: op, operand_a, operand_b, exponent, raw_value, zero fill
  input  logic [((3+2*OPERAND_WIDTH+127+7)/8)*8-1:0] s_axis_tdata,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: residue, zero fill
  output logic [((OPERAND_WIDTH+7)/8)*8-1:0]         m_axis_tdata
);
  import mau_pkg::*;

  localparam int unsigned OW       = OPERAND_WIDTH;
  localparam int unsigned EXP_BITS = (EXPONENT_WIDTH > EXP_FIELD_W) ? EXP_FIELD_W
                                                                    : EXPONENT_WIDTH;
  localparam int unsigned EREG_W   = (EXP_BITS > OW) ? EXP_BITS : OW;
  localparam int unsigned SH_W     = RAW_W;
  localparam int unsigned LCNT_W   = $clog2(SH_W + 1);
  localparam int unsigned ECNT_W   = $clog2(EREG_W + 1);
  localparam int unsigned OUT_W    = ((OW + 7) / 8) * 8;
  localparam int unsigned A_LSB    = OP_W;
  localparam int unsigned B_LSB    = A_LSB + OW;
  localparam int unsigned E_LSB    = B_LSB + OW;
  localparam int unsigned R_LSB    = E_LSB + EXP_FIELD_W;

  // Control state
  seq_state_e        state_q, state_d;
  upc_t              pc_q, pc_d;
  logic [OW-1:0]     mod_q;
  logic              out_valid_q;
  logic [OW-1:0]     out_res_q;

  // Captured beat
  logic [OP_W-1:0]     op_q;
  logic [OW-1:0]       a_q, b_q;
  logic [EXP_BITS-1:0] exp_q;
  logic [RAW_W-1:0]    raw_q;

  // Datapath registers
  logic [OW-1:0]     ra_q, ra_d, rb_q, rb_d, acc_q, acc_d;
  logic [OW-1:0]     add_q, add_d, base_q, base_d;
  logic [SH_W-1:0]   sh_q, sh_d;
  logic [LCNT_W-1:0] lcnt_q, lcnt_d;
  logic [EREG_W-1:0] e_q, e_d;
  logic [ECNT_W-1:0] ecnt_q, ecnt_d;

  ctl_t              ctl;
  logic              in_fire, out_free, run_hold, stall, exec_en, finish, taken;
  logic [OW+1:0]     st_sum, st_m1, st_m2, st_res;
  logic [OW:0]       as_sum, as_m;
  logic [OW-1:0]     as_res, as_rhs;

  assign ctl      = ucode_rom(pc_q);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign run_hold = (ctl.uop == U_RUN) && (lcnt_q != LCNT_W'(1));
  assign stall    = ctl.last && !out_free;
  assign exec_en  = (state_q == ST_EXEC) && !stall;
  assign finish   = exec_en && !run_hold && ctl.last;

  // APB register port
  assign pready = 1'b1;
  assign prdata = 32'(mod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= OW'(MODULUS_RESET);
    end else if (psel && penable && pwrite && (paddr == REG_MODULUS)) begin
      mod_q <= pwdata[OW-1:0];
    end
  end

  // Streams
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(out_res_q);

  // Serial step: acc = 2*acc + bit*addend, brought below m
  assign st_m1  = (OW + 2)'(mod_q);
  assign st_m2  = st_m1 << 1;
  assign st_sum = {1'b0, acc_q, 1'b0} + (OW + 2)'(sh_q[SH_W-1] ? add_q : '0);
  always_comb begin
    if (st_sum >= st_m2) begin
      st_res = st_sum - st_m2;
    end else if (st_sum >= st_m1) begin
      st_res = st_sum - st_m1;
    end else begin
      st_res = st_sum;
    end
  end

  // Add and subtract of reduced residues
  assign as_m   = {1'b0, mod_q};
  assign as_rhs = (ctl.uop == U_SUB) ? (mod_q - rb_q) : rb_q;
  assign as_sum = {1'b0, ra_q} + {1'b0, as_rhs};
  assign as_res = (as_sum >= as_m) ? OW'(as_sum - as_m) : OW'(as_sum);

  // Jump condition
  always_comb begin
    case (ctl.cond)
      C_NEXT:     taken = 1'b0;
      C_JMP:      taken = 1'b1;
      C_M_ZERO:   taken = (mod_q == '0);
      C_M_LT2:    taken = (mod_q < OW'(2));
      C_RA_ZERO:  taken = (ra_q == '0);
      C_RB_ZERO:  taken = (rb_q == '0);
      C_EBIT_CLR: taken = !e_q[EREG_W-1];
      C_EMORE:    taken = (ecnt_q != ECNT_W'(1));
      C_NODIV:    taken = (op_q != OP_DIV);
      C_DISPATCH: taken = 1'b1;
      default:    taken = 1'b0;
    endcase
  end

  // Next state and step counter
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
          pc_d    = L_PREP;
        end
      end
      ST_EXEC: begin
        if (finish) begin
          state_d = ST_IDLE;
        end else if (exec_en && !run_hold) begin
          if (ctl.cond == C_DISPATCH) begin
            pc_d = dispatch(op_q);
          end else if (taken) begin
            pc_d = ctl.target;
          end else begin
            pc_d = pc_q + UPC_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= L_PREP;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  // Datapath actions of the current control word
  always_comb begin
    ra_d   = ra_q;
    rb_d   = rb_q;
    acc_d  = acc_q;
    add_d  = add_q;
    base_d = base_q;
    sh_d   = sh_q;
    lcnt_d = lcnt_q;
    e_d    = e_q;
    ecnt_d = ecnt_q;
    if (exec_en) begin
      case (ctl.uop) inside
        U_LD_A: begin
          sh_d   = SH_W'(a_q) << (SH_W - OW);
          add_d  = OW'(1);
          lcnt_d = LCNT_W'(OW);
          acc_d  = '0;
        end
        U_LD_B: begin
          sh_d   = SH_W'(b_q) << (SH_W - OW);
          add_d  = OW'(1);
          lcnt_d = LCNT_W'(OW);
          acc_d  = '0;
        end
        U_LD_RAW: begin
          sh_d   = raw_q[RAW_W-1] ? (SH_W'(0) - raw_q) : raw_q;
          add_d  = OW'(1);
          lcnt_d = LCNT_W'(SH_W);
          acc_d  = '0;
        end
        U_LD_MUL: begin
          sh_d   = SH_W'(rb_q) << (SH_W - OW);
          add_d  = ra_q;
          lcnt_d = LCNT_W'(OW);
          acc_d  = '0;
        end
        U_LD_SQR: begin
          sh_d   = SH_W'(acc_q) << (SH_W - OW);
          add_d  = acc_q;
          lcnt_d = LCNT_W'(OW);
          acc_d  = '0;
        end
        U_LD_MULB: begin
          sh_d   = SH_W'(acc_q) << (SH_W - OW);
          add_d  = base_q;
          lcnt_d = LCNT_W'(OW);
          acc_d  = '0;
        end
        U_LD_DIV: begin
          sh_d   = SH_W'(acc_q) << (SH_W - OW);
          add_d  = ra_q;
          lcnt_d = LCNT_W'(OW);
          acc_d  = '0;
        end
        U_RUN: begin
          acc_d  = st_res[OW-1:0];
          sh_d   = sh_q << 1;
          lcnt_d = lcnt_q - LCNT_W'(1);
        end
        U_MV_RA: ra_d = acc_q;
        U_MV_RB: rb_d = acc_q;
        U_RAW_FIX: begin
          acc_d = (raw_q[RAW_W-1] && (acc_q != '0)) ? (mod_q - acc_q) : acc_q;
        end
        U_ADD, U_SUB: acc_d = as_res;
        U_POW_E: begin
          base_d = ra_q;
          e_d    = EREG_W'(exp_q) << (EREG_W - EXP_BITS);
          ecnt_d = ECNT_W'(EXP_BITS);
          acc_d  = (mod_q == OW'(1)) ? '0 : OW'(1);
        end
        U_INV_A: begin
          base_d = ra_q;
          e_d    = EREG_W'(mod_q - OW'(2)) << (EREG_W - OW);
          ecnt_d = ECNT_W'(OW);
          acc_d  = OW'(1);
        end
        U_INV_B: begin
          base_d = rb_q;
          e_d    = EREG_W'(mod_q - OW'(2)) << (EREG_W - OW);
          ecnt_d = ECNT_W'(OW);
          acc_d  = OW'(1);
        end
        U_E_NEXT: begin
          e_d    = e_q << 1;
          ecnt_d = ecnt_q - ECNT_W'(1);
        end
        U_CLR: acc_d = '0;
        default: ;
      endcase
    end
  end

  // Loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcnt_q <= '0;
      ecnt_q <= '0;
    end else begin
      lcnt_q <= lcnt_d;
      ecnt_q <= ecnt_d;
    end
  end

  // Datapath payload
  always_ff @(posedge clk_i) begin
    ra_q   <= ra_d;
    rb_q   <= rb_d;
    acc_q  <= acc_d;
    add_q  <= add_d;
    base_q <= base_d;
    sh_q   <= sh_d;
    e_q    <= e_d;
  end

  // Capture the accepted beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= s_axis_tdata[OP_W-1:0];
      a_q   <= s_axis_tdata[A_LSB +: OW];
      b_q   <= s_axis_tdata[B_LSB +: OW];
      exp_q <= s_axis_tdata[E_LSB +: EXP_BITS];
      raw_q <= s_axis_tdata[R_LSB +: RAW_W];
    end
  end

  // Output register: load on the last step, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_res_q <= acc_d;
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the modular arithmetic unit.
`timescale 1ns / 1ps

module tb_top;
  import mau_pkg::*;

  localparam int unsigned OPW    = 30;
  localparam int unsigned IN_W   = ((3 + 2*OPW + 127 + 7) / 8) * 8;
  localparam int unsigned OUT_W  = ((OPW + 7) / 8) * 8;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam logic [29:0] M_DEF  = 30'd1000000007;
  localparam logic [29:0] ALL1   = '1;
  localparam int unsigned PHASE_ITEMS    = 216;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES    = 4400;

  // One row of directed stimulus; known marks a typed-in result
  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [OPW-1:0]         a;
    logic [OPW-1:0]         b;
    logic [EXP_FIELD_W-1:0] e;
    logic [RAW_W-1:0]       raw;
    logic                   known;
    logic [OPW-1:0]         res;
  } vector_t;

  localparam int unsigned NUM_DIRECTED = 25;
  localparam vector_t DIRECTED_VECS [NUM_DIRECTED] = '{
    '{OP_REDUCE, 30'd0, 30'd0, 63'd0, 64'd0,                   1'b1, 30'd0},
    '{OP_REDUCE, 30'd0, 30'd0, 63'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 30'd1000000006},
    '{OP_REDUCE, 30'd0, 30'd0, 63'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 30'd0},
    '{OP_REDUCE, 30'd0, 30'd0, 63'd0, 64'h8000_0000_0000_0000, 1'b0, 30'd0},
    '{OP_REDUCE, 30'd0, 30'd0, 63'd0, 64'd1000000007,          1'b1, 30'd0},
    '{OP_REDUCE, 30'd0, 30'd0, 63'd0, -64'd1000000007,         1'b1, 30'd0},
    '{OP_ADD, 30'd1000000006, 30'd1, 63'd0, 64'd0,             1'b1, 30'd0},
    '{OP_ADD, ALL1, ALL1, 63'd0, 64'd0,                        1'b0, 30'd0},
    '{OP_SUB, 30'd0, 30'd1, 63'd0, 64'd0,                      1'b1, 30'd1000000006},
    '{OP_SUB, 30'd5, 30'd5, 63'd0, 64'd0,                      1'b1, 30'd0},
    '{OP_MUL, 30'd1000000006, 30'd1000000006, 63'd0, 64'd0,    1'b1, 30'd1},
    '{OP_MUL, ALL1, 30'd0, 63'd0, 64'd0,                       1'b1, 30'd0},
    '{OP_POW, 30'd12345, 30'd0, 63'd0, 64'd0,                  1'b1, 30'd1},
    '{OP_POW, 30'd0, 30'd0, 63'd0, 64'd0,                      1'b1, 30'd1},
    '{OP_POW, 30'd2, 30'd0, 63'd10, 64'd0,                     1'b1, 30'd1024},
    '{OP_POW, 30'd1000000006, 30'd0, '1, 64'd0,                1'b1, 30'd1000000006},
    '{OP_POW, 30'd123456789, ALL1, '1, '1,                     1'b0, 30'd0},
    '{OP_INV, 30'd0, 30'd0, 63'd0, 64'd0,                      1'b1, 30'd0},
    '{OP_INV, 30'd1, 30'd0, 63'd0, 64'd0,                      1'b1, 30'd1},
    '{OP_INV, 30'd2, 30'd0, 63'd0, 64'd0,                      1'b1, 30'd500000004},
    '{OP_INV, 30'd1000000006, 30'd0, 63'd0, 64'd0,             1'b1, 30'd1000000006},
    '{OP_DIV, 30'd7, 30'd0, 63'd0, 64'd0,                      1'b1, 30'd0},
    '{OP_DIV, 30'd6, 30'd3, 63'd0, 64'd0,                      1'b1, 30'd2},
    '{OP_DIV, ALL1, ALL1, 63'd0, 64'd0,                        1'b0, 30'd0},
    '{OP_UNUSED, ALL1, ALL1, '1, '1,                           1'b1, 30'd0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  // tdata: op, operand_a, operand_b, exponent, raw_value, zero fill
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // tdata: residue, zero fill
  logic [OUT_W-1:0] m_axis_tdata;

  logic [OPW-1:0] cur_modulus;
  logic [OPW-1:0] expected_residues [$];
  int unsigned    err_count;
  int unsigned    tx_idle_pct;
  int unsigned    rx_idle_pct;
  int unsigned    hold_req;
  int unsigned    hold_ack = 0;
  int unsigned    hold_left = 0;

  modular_arithmetic_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #600_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Square and multiply from the top exponent bit down; x < m, m >= 1
  function automatic logic [63:0] mod_power(logic [63:0] x, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1 % m;
    for (int i = 63; i >= 0; i--) begin
      acc = (acc * acc) % m;
      if (e[i]) begin
        acc = (acc * x) % m;
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] mod_inverse(logic [63:0] x, logic [63:0] m);
    if (x == 64'd0) begin
      return 64'd0;
    end
    return mod_power(x, m - 64'd2, m);
  endfunction

  // Expected residue of one operation under modulus m
  function automatic logic [OPW-1:0] predict_residue(logic [OPW-1:0] m_in, logic [OP_W-1:0] op,
                                                     logic [OPW-1:0] a_in, logic [OPW-1:0] b_in,
                                                     logic [EXP_FIELD_W-1:0] e,
                                                     logic [RAW_W-1:0] raw);
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r;
    logic [63:0] t;
    m = {34'd0, m_in};
    if (m == 64'd0) begin
      return '0;
    end
    a = {34'd0, a_in} % m;
    b = {34'd0, b_in} % m;
    r = 64'd0;
    case (op)
      OP_REDUCE: begin
        if (raw[63]) begin
          t = (64'd0 - raw) % m;
          r = (t == 64'd0) ? 64'd0 : m - t;
        end else begin
          r = raw % m;
        end
      end
      OP_ADD: r = (a + b) % m;
      OP_SUB: r = (a + (m - b)) % m;
      OP_MUL: r = (a * b) % m;
      OP_POW: r = mod_power(a, {1'b0, e}, m);
      OP_INV: r = (m < 64'd2) ? 64'd0 : mod_inverse(a, m);
      OP_DIV: r = (m < 64'd2) ? 64'd0 : (a * mod_inverse(b, m)) % m;
      default: r = 64'd0;
    endcase
    return r[OPW-1:0];
  endfunction

  // Offer one beat, leaving tvalid high after the handshake
  task automatic send_item(input logic [OP_W-1:0] op, input logic [OPW-1:0] a,
                           input logic [OPW-1:0] b, input logic [EXP_FIELD_W-1:0] e,
                           input logic [RAW_W-1:0] raw, input logic [OPW-1:0] res);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W-190){1'b0}}, raw, e, b, a, op};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_residues.push_back(res);
  endtask

  // Drop tvalid and hold until every result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_residues.size() != 0);
  endtask

  // Write the modulus register, then read it back
  task automatic program_modulus(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_MODULUS;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cur_modulus = value[OPW-1:0];
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[OPW-1:0] !== cur_modulus) begin
      $display("%0t: modulus readback mismatch: expected %0d, actual %0d",
               $time, cur_modulus, prdata[OPW-1:0]);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [OPW-1:0] rand_operand(logic [OPW-1:0] m);
    case ($urandom_range(19)) inside
      0:       return '0;
      1:       return (m != 0) ? m - 1'b1 : '0;
      2:       return '1;
      3, 4:    return OPW'($urandom());
      default: return (m != 0) ? OPW'($urandom() % m) : OPW'($urandom());
    endcase
  endfunction

  function automatic logic [EXP_FIELD_W-1:0] rand_exponent(logic [OPW-1:0] m);
    logic [63:0] full;
    full = {$urandom(), $urandom()};
    case ($urandom_range(7))
      0:       return '0;
      1:       return EXP_FIELD_W'($urandom_range(1, 40));
      2:       return {31'd0, full[31:0]};
      3:       return '1;
      4:       return {33'd0, m} - 63'd2;
      default: return full[EXP_FIELD_W-1:0];
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] rand_raw(logic [OPW-1:0] m);
    logic [63:0] k;
    k = 64'($urandom_range(1, 1000));
    case ($urandom_range(9))
      1:       return 64'($urandom_range(0, 2000)) - 64'd1000;
      2:       return 64'h8000_0000_0000_0000;
      3:       return 64'h7FFF_FFFF_FFFF_FFFF;
      4:       return k * {34'd0, m};
      5:       return 64'd0 - k * {34'd0, m};
      6:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Weighted toward the cheap operations; power and inverse run long
  function automatic logic [OP_W-1:0] rand_op();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 19) return OP_REDUCE;
    if (pick < 38) return OP_ADD;
    if (pick < 57) return OP_SUB;
    if (pick < 75) return OP_MUL;
    if (pick < 85) return OP_POW;
    if (pick < 91) return OP_INV;
    if (pick < 97) return OP_DIV;
    return OP_UNUSED;
  endfunction

  // Result side: random stalls plus a single long hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_left     <= RX_HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_residues.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %0d",
                 $time, m_axis_tdata[OPW-1:0]);
        err_count++;
      end else begin
        logic [OPW-1:0] want;
        want = expected_residues.pop_front();
        if (m_axis_tdata[OPW-1:0] !== want) begin
          $display("%0t: residue mismatch: expected %0d, actual %0d",
                   $time, want, m_axis_tdata[OPW-1:0]);
          err_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [31:0]          phase_moduli [NUM_PHASES];
    logic [OP_W-1:0]      op;
    logic [OPW-1:0]       a;
    logic [OPW-1:0]       b;
    logic [EXP_FIELD_W-1:0] e;
    logic [RAW_W-1:0]     raw;
    logic [OPW-1:0]       res;
    int unsigned          n_random;
    int unsigned          tail;

    err_count     = 0;
    hold_req      = 0;
    tx_idle_pct   = 12;
    rx_idle_pct   = 45;
    n_random      = 0;
    cur_modulus   = M_DEF;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;

    phase_moduli = '{32'd1073741823, 32'd2, 32'd0, 32'd1, 32'd998244353, 32'd13,
                     32'($urandom_range(3, 1073741823)), 32'd1000000007};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at the modulus left by reset
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      res = DIRECTED_VECS[i].known ? DIRECTED_VECS[i].res
          : predict_residue(cur_modulus, DIRECTED_VECS[i].op, DIRECTED_VECS[i].a,
                            DIRECTED_VECS[i].b, DIRECTED_VECS[i].e, DIRECTED_VECS[i].raw);
      send_item(DIRECTED_VECS[i].op, DIRECTED_VECS[i].a, DIRECTED_VECS[i].b,
                DIRECTED_VECS[i].e, DIRECTED_VECS[i].raw, res);
    end

    // Random items, one modulus per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      program_modulus(phase_moduli[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // swap, then drop, the idling pattern by thirds of the run
        if (n_random < NUM_PHASES * PHASE_ITEMS / 3) begin
          tx_idle_pct = 12;
          rx_idle_pct = 45;
        end else if (n_random < 2 * NUM_PHASES * PHASE_ITEMS / 3) begin
          tx_idle_pct = 45;
          rx_idle_pct = 12;
        end else begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        if (p == 4 && i == 20) begin
          hold_req++;
        end
        if (p == 5 && i == 100) begin
          drain_results();
        end
        op  = rand_op();
        a   = rand_operand(cur_modulus);
        b   = rand_operand(cur_modulus);
        e   = rand_exponent(cur_modulus);
        raw = rand_raw(cur_modulus);
        res = predict_residue(cur_modulus, op, a, b, e, raw);
        send_item(op, a, b, e, raw, res);
        n_random++;
      end
    end

    // Let the last results arrive, then watch for strays
    drain_results();
    tail = 0;
    while (tail < TAIL_CYCLES) begin
      @(posedge clk_i);
      tail++;
    end
    if (expected_residues.size() != 0) begin
      err_count++;
    end

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/mau_pkg.sv
design/modular_arithmetic_unit.sv
tb/sv/tb_top.sv
